/* rtl/authenticator_data_parser_core_macros.svh */
// ---------------------------------------------------------------------------
// authenticator data parser assertion macros
// shared helpers for the port-level checker
// ---------------------------------------------------------------------------
`ifndef AUTHENTICATOR_DATA_PARSER_CORE_MACROS_SVH
`define AUTHENTICATOR_DATA_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ADP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ADP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/adp_pkg.sv */
// ---------------------------------------------------------------------------
// adp_pkg
// types, codes and constants of the authenticator data parser
// ---------------------------------------------------------------------------
`default_nettype none

package adp_pkg;

  localparam int LEN_W      = 17;  // width of the byte and region counters
  localparam int IDX_W      = 17;  // width of region_index and key_length ports
  localparam int CNT_W      = 32;
  localparam int IDL_W      = 16;
  localparam int PREFIX_LEN = 37;
  localparam int HASH_LEN   = 32;
  localparam int COUNT_LEN  = 4;
  localparam int AAGUID_LEN = 16;
  localparam int IDLEN_LEN  = 2;
  localparam int FLAG_AT_BIT = 6;

  localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

  // region codes as seen on the result port
  localparam logic [2:0] RG_HASH    = 3'd0;
  localparam logic [2:0] RG_FLAGS   = 3'd1;
  localparam logic [2:0] RG_COUNT   = 3'd2;
  localparam logic [2:0] RG_AAGUID  = 3'd3;
  localparam logic [2:0] RG_IDLEN   = 3'd4;
  localparam logic [2:0] RG_CREDID  = 3'd5;
  localparam logic [2:0] RG_KEY     = 3'd6;
  localparam logic [2:0] RG_IGNORED = 3'd7;

  // parse status codes
  localparam logic [1:0] PS_OK       = 2'd0;
  localparam logic [1:0] PS_SHORT    = 2'd1;
  localparam logic [1:0] PS_TOO_LONG = 2'd2;

  // region tracker state
  typedef enum logic [7:0] {
    ST_HASH    = 8'b0000_0001,
    ST_FLAGS   = 8'b0000_0010,
    ST_COUNT   = 8'b0000_0100,
    ST_AAGUID  = 8'b0000_1000,
    ST_IDLEN   = 8'b0001_0000,
    ST_CREDID  = 8'b0010_0000,
    ST_KEY     = 8'b0100_0000,
    ST_IGNORED = 8'b1000_0000
  } region_state_t;

  typedef struct packed {
    logic [7:0]       byte_echo;
    logic [2:0]       region;
    logic [IDX_W-1:0] region_index;
    logic             message_done;
    logic [1:0]       parse_status;
    logic [7:0]       flags_out;
    logic [CNT_W-1:0] sign_counter;
    logic [IDL_W-1:0] credential_id_length;
    logic [IDX_W-1:0] key_length;
  } result_t;

  function automatic logic [2:0] region_code(input region_state_t st);
    logic [2:0] code;
    case (st)
      ST_HASH:   code = RG_HASH;
      ST_FLAGS:  code = RG_FLAGS;
      ST_COUNT:  code = RG_COUNT;
      ST_AAGUID: code = RG_AAGUID;
      ST_IDLEN:  code = RG_IDLEN;
      ST_CREDID: code = RG_CREDID;
      ST_KEY:    code = RG_KEY;
      default:   code = RG_IGNORED;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/adp_tagger.sv */
// ---------------------------------------------------------------------------
// adp_tagger
// region tracker: tags one byte per step and builds the message summary
// ---------------------------------------------------------------------------
`default_nettype none

module adp_tagger
  import adp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_in,
  output result_t         result
);

  region_state_t     region_r, region_nxt;
  logic [LEN_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [LEN_W-1:0]  reg_pos_r, reg_pos_nxt;
  logic [7:0]        flags_r, flags_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDL_W-1:0]  idl_r, idl_nxt;
  logic [LEN_W-1:0]  key_cnt_r, key_cnt_nxt;
  logic              ovf_r, ovf_nxt;

  logic              ovf_now;
  logic [LEN_W-1:0]  pos_inc;
  logic [LEN_W:0]    pos_plus1;

  assign ovf_now   = ovf_r || (byte_pos_r == POS_MAX);
  assign pos_inc   = reg_pos_r + LEN_W'(1);
  assign pos_plus1 = {1'b0, reg_pos_r} + (LEN_W+1)'(1);

  always_comb begin
    region_nxt   = region_r;
    byte_pos_nxt = byte_pos_r;
    reg_pos_nxt  = reg_pos_r;
    flags_nxt    = flags_r;
    count_nxt    = count_r;
    idl_nxt      = idl_r;
    key_cnt_nxt  = key_cnt_r;
    ovf_nxt      = ovf_r;

    if (ovf_now) begin
      ovf_nxt = 1'b1;
    end else begin
      byte_pos_nxt = byte_pos_r + LEN_W'(1);
      reg_pos_nxt  = pos_inc;
      case (region_r)
        ST_HASH: begin
          if (reg_pos_r >= LEN_W'(HASH_LEN - 1)) begin
            region_nxt  = ST_FLAGS;
            reg_pos_nxt = '0;
          end
        end
        ST_FLAGS: begin
          flags_nxt   = byte_in;
          region_nxt  = ST_COUNT;
          reg_pos_nxt = '0;
        end
        ST_COUNT: begin
          count_nxt = {count_r[CNT_W-9:0], byte_in};
          if (reg_pos_r >= LEN_W'(COUNT_LEN - 1)) begin
            region_nxt  = flags_r[FLAG_AT_BIT] ? ST_AAGUID : ST_IGNORED;
            reg_pos_nxt = '0;
          end
        end
        ST_AAGUID: begin
          if (reg_pos_r >= LEN_W'(AAGUID_LEN - 1)) begin
            region_nxt  = ST_IDLEN;
            reg_pos_nxt = '0;
          end
        end
        ST_IDLEN: begin
          idl_nxt = {idl_r[IDL_W-9:0], byte_in};
          if (reg_pos_r >= LEN_W'(IDLEN_LEN - 1)) begin
            region_nxt  = (idl_nxt == '0) ? ST_KEY : ST_CREDID;
            reg_pos_nxt = '0;
          end
        end
        ST_CREDID: begin
          if (pos_plus1 >= (LEN_W+1)'(idl_r)) begin
            region_nxt  = ST_KEY;
            reg_pos_nxt = '0;
          end
        end
        ST_KEY: begin
          key_cnt_nxt = key_cnt_r + LEN_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // result for the byte in flight
  always_comb begin
    result                      = '0;
    result.byte_echo            = byte_in;
    result.region               = ovf_now ? RG_IGNORED : region_code(region_r);
    result.region_index         = ovf_now ? '0 : IDX_W'(reg_pos_r);
    result.message_done         = last_in;
    if (last_in) begin
      if (ovf_nxt) begin
        result.parse_status = PS_TOO_LONG;
      end else if (byte_pos_nxt < LEN_W'(PREFIX_LEN)) begin
        result.parse_status = PS_SHORT;
      end else begin
        result.flags_out    = flags_nxt;
        result.sign_counter = count_nxt;
        if (region_nxt == ST_KEY || region_nxt == ST_IGNORED) begin
          result.parse_status = PS_OK;
          if (flags_nxt[FLAG_AT_BIT]) begin
            result.credential_id_length = idl_nxt;
            result.key_length           = IDX_W'(key_cnt_nxt);
          end
        end else begin
          result.parse_status = PS_SHORT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_in)) begin
      region_r   <= ST_HASH;
      byte_pos_r <= '0;
      reg_pos_r  <= '0;
      flags_r    <= '0;
      count_r    <= '0;
      idl_r      <= '0;
      key_cnt_r  <= '0;
      ovf_r      <= 1'b0;
    end else if (step) begin
      region_r   <= region_nxt;
      byte_pos_r <= byte_pos_nxt;
      reg_pos_r  <= reg_pos_nxt;
      flags_r    <= flags_nxt;
      count_r    <= count_nxt;
      idl_r      <= idl_nxt;
      key_cnt_r  <= key_cnt_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/authenticator_data_parser_core.sv */
// ---------------------------------------------------------------------------
// authenticator_data_parser_core
// streaming parser for authenticator data, one byte per transfer
// ---------------------------------------------------------------------------
// Bytes of an authenticator data message enter one per transfer, the final one
// marked by in_last_byte, and each leaves as one result transfer tagged with
// its region (rpId hash, flags, sign count, aaguid, credential id length,
// credential id, public key, or ignored) and its index in that region. The
// result for the marked byte also carries the summary: status, flags, sign
// count, credential id length and key length; the parser then starts over for
// the next message. The block takes one byte every clock cycle with results
// taken in every cycle, and a byte's result passes through the input
// register, then the result register. The rate is set by the region
// tracker, whose counters and captured fields update once per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module authenticator_data_parser_core
  import adp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // byte input
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte_value,
  input  wire logic             in_last_byte,
  // tagged byte output
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte_echo,
  output logic [2:0]            out_region,
  output logic [IDX_W-1:0]      out_region_index,
  output logic                  out_message_done,
  output logic [1:0]            out_parse_status,
  output logic [7:0]            out_flags_out,
  output logic [CNT_W-1:0]      out_sign_counter,
  output logic [IDL_W-1:0]      out_credential_id_length,
  output logic [IDX_W-1:0]      out_key_length
);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // result register
  logic       out_v_r, out_v_nxt;
  result_t    out_r;
  result_t    result;

  logic       out_free;   // result register can load this cycle
  logic       step;       // byte in the input register moves to the result
  logic       in_xfer;

  assign out_free = !out_v_r || out_ready;
  assign step     = in_v_r && out_free;
  assign in_ready = !in_v_r || step;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_xfer) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_byte_value;
      in_last_r <= in_last_byte;
    end
    if (step) begin
      out_r <= result;
    end
  end

  // region tracking and summary, state advances on each step
  adp_tagger u_tagger (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .last_in (in_last_r),
    .result  (result)
  );

  assign out_valid                = out_v_r;
  assign out_byte_echo            = out_r.byte_echo;
  assign out_region               = out_r.region;
  assign out_region_index         = out_r.region_index;
  assign out_message_done         = out_r.message_done;
  assign out_parse_status         = out_r.parse_status;
  assign out_flags_out            = out_r.flags_out;
  assign out_sign_counter         = out_r.sign_counter;
  assign out_credential_id_length = out_r.credential_id_length;
  assign out_key_length           = out_r.key_length;

endmodule

`default_nettype wire

/* rtl/adp_checker.sv */
// ---------------------------------------------------------------------------
// adp_checker
// port-level checks on the parser result stream
// ---------------------------------------------------------------------------
`default_nettype none

`include "authenticator_data_parser_core_macros.svh"

module adp_checker
  import adp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [7:0]       out_byte_echo,
  input wire logic [2:0]       out_region,
  input wire logic [IDX_W-1:0] out_region_index,
  input wire logic             out_message_done,
  input wire logic [1:0]       out_parse_status,
  input wire logic [7:0]       out_flags_out,
  input wire logic [CNT_W-1:0] out_sign_counter,
  input wire logic [IDL_W-1:0] out_credential_id_length,
  input wire logic [IDX_W-1:0] out_key_length
);

  `ADP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte_echo) && $stable(out_region_index), "result changed while stalled")

  `ADP_ASSERT_NOW(a_summary_zero, out_valid && !out_message_done, out_parse_status == PS_OK && out_flags_out == 8'd0 && out_sign_counter == '0 && out_credential_id_length == '0 && out_key_length == '0, "summary set on a non-final byte")

  `ADP_ASSERT_NOW(a_too_long_tag, out_valid && out_parse_status == PS_TOO_LONG, out_message_done && out_region == RG_IGNORED && out_region_index == '0, "too-long result not tagged ignored")

  `ADP_ASSERT_NOW(a_assert_form, out_valid && out_message_done && out_parse_status == PS_OK && !out_flags_out[FLAG_AT_BIT], out_credential_id_length == '0 && out_key_length == '0, "lengths reported without attested data")

  `ADP_ASSERT_NOW(a_hash_index, out_valid && out_region == RG_HASH, out_region_index < IDX_W'(HASH_LEN), "hash index out of range")

endmodule

bind authenticator_data_parser_core adp_checker u_adp_checker (.*);

`default_nettype wire
